// ===== hdl/rnf_pkg.sv =====
// Shared constants and the digit glyph function for the radix number formatter.
package rnf_pkg;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_UND   = 7'h5F;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_UPA   = 7'h41;

    localparam logic [1:0] REG_BASE  = 2'd0;
    localparam logic [1:0] REG_WIDTH = 2'd1;
    localparam logic [1:0] REG_ZFILL = 2'd2;

    // Glyph for one digit value, upper-case letters above nine.
    function automatic logic [6:0] digit_glyph(input logic [3:0] d);
        logic [6:0] g;
        if (d < 4'd10)
            g = CH_ZERO + {3'd0, d};
        else
            g = CH_UPA + {3'd0, d} - 7'd10;
        return g;
    endfunction

endpackage

// ===== hdl/rnf_front.sv =====
// Front end: takes a number, resolves sign and magnitude, snapshots the config.
module rnf_front
    import rnf_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  is_signed,
    input  logic [4:0]            number_base,
    input  logic [5:0]            min_width,
    input  logic                  zero_fill,
    output logic                  job_valid,
    input  logic                  job_take,
    output logic [VALUE_BITS-1:0] job_mag,
    output logic                  job_neg,
    output logic [4:0]            job_base,
    output logic [5:0]            job_width,
    output logic                  job_zfill
);

    // Two-entry queue between front and back.
    logic [1:0]            cnt_reg, cnt_next;
    logic                  wp_reg, rp_reg;
    logic [VALUE_BITS-1:0] mag_mem [2];
    logic                  neg_mem [2];
    logic [4:0]            base_mem [2];
    logic [5:0]            width_mem [2];
    logic                  zf_mem [2];

    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [4:0]            base_c;
    logic [5:0]            width_c;
    logic                  do_push, do_pop;

    always_comb
    begin
        neg = is_signed & value[VALUE_BITS-1];
        mag = neg ? (~value + 1'b1) : value;
        if (number_base < 5'd2)
            base_c = 5'd2;
        else if (number_base > 5'd16)
            base_c = 5'd16;
        else
            base_c = number_base;
        width_c = (neg && min_width != 6'd0) ? min_width - 6'd1 : min_width;
    end

    assign full      = (cnt_reg == 2'd2);
    assign do_push   = push & ~full;
    assign job_valid = (cnt_reg != 2'd0);
    assign do_pop    = job_take & job_valid;
    assign cnt_next  = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
                wp_reg <= ~wp_reg;
            if (do_pop)
                rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mag_mem[wp_reg]   <= mag;
            neg_mem[wp_reg]   <= neg;
            base_mem[wp_reg]  <= base_c;
            width_mem[wp_reg] <= width_c;
            zf_mem[wp_reg]    <= zero_fill;
        end
    end

    assign job_mag   = mag_mem[rp_reg];
    assign job_neg   = neg_mem[rp_reg];
    assign job_base  = base_mem[rp_reg];
    assign job_width = width_mem[rp_reg];
    assign job_zfill = zf_mem[rp_reg];

    property p_cnt_bound;
        @(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3;
    endproperty
    a_cnt_bound: assert property (p_cnt_bound) else $error("queue count out of range");

    property p_no_push_full;
        @(posedge clk) disable iff (!rst_n) full |-> !do_push;
    endproperty
    a_no_push_full: assert property (p_no_push_full) else $error("push while full");

    property p_pop_grows_not;
        @(posedge clk) disable iff (!rst_n) (do_pop && !do_push) |=> cnt_reg == $past(cnt_reg) - 2'd1;
    endproperty
    a_pop_grows_not: assert property (p_pop_grows_not) else $error("pop count mismatch");

endmodule

// ===== hdl/rnf_back.sv =====
// Back end: digit divider, text buffer build, then character emission.
module rnf_back
    import rnf_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_CHARS  = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    output logic                  job_take,
    input  logic [VALUE_BITS-1:0] job_mag,
    input  logic                  job_neg,
    input  logic [4:0]            job_base,
    input  logic [5:0]            job_width,
    input  logic                  job_zfill,
    output logic                  empty,
    input  logic                  pop,
    output logic [6:0]            char_code,
    output logic                  last_char,
    output logic                  overflow
);

    localparam int LW = $clog2(MAX_CHARS + 3);
    localparam int AW = $clog2(MAX_CHARS);
    localparam int CW = $clog2(VALUE_BITS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_DIG  = 3'd2;
    localparam logic [2:0] ST_FILL = 3'd3;
    localparam logic [2:0] ST_SIGN = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] quo_reg;
    logic [4:0]            rem_reg;
    logic [CW-1:0]         bit_reg;
    logic [VALUE_BITS-1:0] mag_reg;
    logic                  neg_reg, zf_reg;
    logic [4:0]            base_reg;
    logic [5:0]            width_reg;
    logic [7:0]            tgt_reg;
    logic [LW-1:0]         len_reg;
    logic [2:0]            dcnt_reg;
    logic                  ovf_reg;
    logic [LW-1:0]         pos_reg;
    logic [6:0]            rev_mem [MAX_CHARS];

    // Output register.
    logic       ov_reg;
    logic [6:0] oc_reg;
    logic       ol_reg, oo_reg;

    logic [5:0]    trial;
    logic          emit_go;
    logic [6:0]    rd_ch;
    logic [11:0]   w_x52;

    assign job_take  = (state_reg == ST_IDLE) & job_valid;
    assign empty     = ~ov_reg;
    assign char_code = oc_reg;
    assign last_char = ol_reg;
    assign overflow  = oo_reg;
    assign emit_go   = (state_reg == ST_EMIT) & (~ov_reg | pop);
    assign trial     = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign rd_ch     = rev_mem[AW'(pos_reg - 1'b1)];
    // width / 5 as (width * 52) >> 8, exact for widths up to 63
    assign w_x52     = {6'd0, job_width} * 12'd52;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (job_valid)
                    state_next = ST_DIV;
            ST_DIV:
                if (bit_reg == CW'(VALUE_BITS))
                    state_next = ST_DIG;
            ST_DIG:
                state_next = (mag_reg == '0 || ovf_reg) ? ST_FILL : ST_DIV;
            ST_FILL:
                if (ovf_reg ||
                    (zf_reg ? ({{(8-LW){1'b0}}, len_reg} >= tgt_reg)
                            : ({{(8-LW){1'b0}}, len_reg} >= {2'd0, width_reg})))
                    state_next = ST_SIGN;
            ST_SIGN:
                state_next = ST_EMIT;
            ST_EMIT:
                if (emit_go && (ovf_reg || pos_reg == LW'(1)))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_go)
                ov_reg <= 1'b1;
            else if (pop)
                ov_reg <= 1'b0;
        end
    end

    // Loads the job, divides, and appends characters to the reversed buffer; beyond capacity only flags overflow.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mag_reg   <= job_mag;
                neg_reg   <= job_neg;
                zf_reg    <= job_zfill;
                base_reg  <= job_base;
                width_reg <= job_width;
                tgt_reg   <= {2'd0, job_width} + {4'd0, w_x52[11:8]};
                len_reg   <= (job_mag == '0) ? LW'(1) : '0;
                dcnt_reg  <= (job_mag == '0) ? 3'd1 : 3'd0;
                ovf_reg   <= 1'b0;
                quo_reg   <= job_mag;
                rem_reg   <= 5'd0;
                bit_reg   <= '0;
                if (job_mag == '0)
                    rev_mem[0] <= CH_ZERO;
            end
            ST_DIV:
            begin
                if (bit_reg != CW'(VALUE_BITS))
                begin
                    if (trial >= {1'b0, base_reg})
                    begin
                        rem_reg <= 5'(trial - {1'b0, base_reg});
                        quo_reg <= {quo_reg[VALUE_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= trial[4:0];
                        quo_reg <= {quo_reg[VALUE_BITS-2:0], 1'b0};
                    end
                    bit_reg <= bit_reg + 1'b1;
                end
            end
            ST_DIG:
            begin
                if (mag_reg != '0 && !ovf_reg)
                begin
                    if (dcnt_reg == 3'd4)
                    begin
                        if (len_reg + 2'd2 > LW'(MAX_CHARS))
                            ovf_reg <= 1'b1;
                        else
                        begin
                            rev_mem[AW'(len_reg)]        <= CH_UND;
                            rev_mem[AW'(len_reg + 1'b1)] <= digit_glyph(rem_reg[3:0]);
                        end
                        len_reg  <= len_reg + 2'd2;
                        dcnt_reg <= 3'd1;
                    end
                    else
                    begin
                        if (len_reg >= LW'(MAX_CHARS))
                            ovf_reg <= 1'b1;
                        else
                            rev_mem[AW'(len_reg)] <= digit_glyph(rem_reg[3:0]);
                        len_reg  <= len_reg + 1'b1;
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end
                    mag_reg <= quo_reg;
                    quo_reg <= quo_reg;
                    rem_reg <= 5'd0;
                    bit_reg <= '0;
                end
            end
            ST_FILL:
            begin
                if (state_next == ST_FILL)
                begin
                    // zero fill keeps the grouping: a full group gets '_' and a zero together
                    if (zf_reg && dcnt_reg == 3'd4)
                    begin
                        if (len_reg + 2'd2 > LW'(MAX_CHARS))
                            ovf_reg <= 1'b1;
                        else
                        begin
                            rev_mem[AW'(len_reg)]        <= CH_UND;
                            rev_mem[AW'(len_reg + 1'b1)] <= CH_ZERO;
                        end
                        len_reg  <= len_reg + 2'd2;
                        dcnt_reg <= 3'd1;
                    end
                    else
                    begin
                        if (len_reg >= LW'(MAX_CHARS))
                            ovf_reg <= 1'b1;
                        else
                            rev_mem[AW'(len_reg)] <= zf_reg ? CH_ZERO : CH_SPACE;
                        len_reg  <= len_reg + 1'b1;
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end
                end
                pos_reg <= len_reg;
            end
            ST_SIGN:
            begin
                if (neg_reg)
                begin
                    if (len_reg >= LW'(MAX_CHARS))
                        ovf_reg <= 1'b1;
                    else
                        rev_mem[AW'(len_reg)] <= CH_MINUS;
                    pos_reg <= len_reg + 1'b1;
                end
                else
                    pos_reg <= len_reg;
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    oo_reg <= ovf_reg;
                    oc_reg <= ovf_reg ? 7'd0 : rd_ch;
                    ol_reg <= ovf_reg | (pos_reg == LW'(1));
                    pos_reg <= pos_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    property p_emit_has_room;
        @(posedge clk) disable iff (!rst_n) emit_go |=> !empty;
    endproperty
    a_emit_has_room: assert property (p_emit_has_room) else $error("result lost");

    property p_idle_after_last;
        @(posedge clk) disable iff (!rst_n)
            (emit_go && (ovf_reg || pos_reg == LW'(1))) |=> state_reg == ST_IDLE;
    endproperty
    a_idle_after_last: assert property (p_idle_after_last) else $error("no return to idle");

    property p_emit_pos;
        @(posedge clk) disable iff (!rst_n)
            (state_reg == ST_EMIT && !ovf_reg) |-> pos_reg != '0;
    endproperty
    a_emit_pos: assert property (p_emit_pos) else $error("emit past buffer start");

endmodule

// ===== hdl/radix_number_formatter.sv =====
// Top level of the radix number formatter.
// Flow: queue, take, then per digit a 32-step divide, check and write, a final divide for the
// zero quotient, fill steps, the sign, then characters, held while the output register is full.
// The back end handles one number at a time; a two-entry queue buffers the front.
// Overflow gives a single result; reset (rst_n low, asynchronous) clears queues and control,
// config returns to base 10, width 0, space fill.
module radix_number_formatter
    import rnf_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_CHARS  = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic [VALUE_BITS-1:0] value,
    input  logic                  is_signed,
    output logic                  empty,
    input  logic                  pop,
    output logic [6:0]            char_code,
    output logic                  last_char,
    output logic                  overflow,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [5:0]            cfg_data
);

    logic [4:0] base_reg;
    logic [5:0] width_reg;
    logic       zf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= 5'd10;
            width_reg <= 6'd0;
            zf_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE:  base_reg  <= cfg_data[4:0];
                REG_WIDTH: width_reg <= cfg_data;
                REG_ZFILL: zf_reg    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    logic                  job_valid, job_take, job_neg, job_zfill;
    logic [VALUE_BITS-1:0] job_mag;
    logic [4:0]            job_base;
    logic [5:0]            job_width;

    rnf_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .value(value),
        .is_signed(is_signed), .number_base(base_reg), .min_width(width_reg),
        .zero_fill(zf_reg), .job_valid(job_valid), .job_take(job_take),
        .job_mag(job_mag), .job_neg(job_neg), .job_base(job_base),
        .job_width(job_width), .job_zfill(job_zfill)
    );

    rnf_back #(.VALUE_BITS(VALUE_BITS), .MAX_CHARS(MAX_CHARS)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_take(job_take),
        .job_mag(job_mag), .job_neg(job_neg), .job_base(job_base),
        .job_width(job_width), .job_zfill(job_zfill), .empty(empty), .pop(pop),
        .char_code(char_code), .last_char(last_char), .overflow(overflow)
    );

endmodule
